>>> rtl/bst_pkg.sv
// shared types, constants and mask-table functions for the binary shrink/thin/skeleton pass
`default_nettype none
package bst_pkg;

  localparam int unsigned WinW  = 25;
  localparam int unsigned PatW  = 8;
  localparam int unsigned ModeW = 2;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [ModeW-1:0] MODE_SHRINK = 2'd0;
  localparam logic [ModeW-1:0] MODE_THIN   = 2'd1;
  localparam logic [ModeW-1:0] MODE_SKEL   = 2'd2;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  localparam logic [AddrW-1:0] REG_MODE = 3'd0;

  // one-hot selectors into the conditional table membership
  localparam logic [2:0] SEL_S = 3'b001;
  localparam logic [2:0] SEL_T = 3'b010;
  localparam logic [2:0] SEL_K = 3'b100;

  typedef struct packed {
    logic new_pixel;
    logic marked;
    logic isolated;
  } bst_res_t;

  // neighbour offsets in packing order E, SE, S, SW, W, NW, N, NE
  localparam int DR [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
  localparam int DC [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

  function automatic logic [PatW-1:0] pattern_at(input logic [WinW-1:0] w,
                                                 input int r, input int c);
    logic [PatW-1:0] v;
    v = '0;
    for (int k = 0; k < 8; k++) begin
      v[k] = w[5 * (r + DR[k]) + (c + DC[k])];
    end
    return v;
  endfunction

  function automatic logic [2:0] mode_sel(input logic [ModeW-1:0] m);
    logic [2:0] s;
    unique case (m)
      MODE_SHRINK: s = SEL_S;
      MODE_THIN:   s = SEL_T;
      MODE_SKEL:   s = SEL_K;
      default:     s = 3'b000;
    endcase
    return s;
  endfunction

  // modes whose conditional table holds this pattern
  function automatic logic [2:0] cond_modes(input logic [PatW-1:0] v);
    logic [2:0] s;
    unique case (v)
      8'd128, 8'd32, 8'd8, 8'd2, 8'd1, 8'd64, 8'd16, 8'd4,
      8'd129, 8'd192, 8'd96, 8'd48, 8'd24, 8'd12, 8'd6, 8'd3:
        s = SEL_S;
      8'd65, 8'd80, 8'd20, 8'd5:
        s = SEL_T | SEL_K;
      8'd97, 8'd67, 8'd208, 8'd133, 8'd193, 8'd112, 8'd28, 8'd7,
      8'd99, 8'd216:
        s = SEL_S | SEL_T;
      8'd131, 8'd224, 8'd56, 8'd14,
      8'd225, 8'd195, 8'd240, 8'd120, 8'd60, 8'd30, 8'd15, 8'd135,
      8'd227, 8'd248, 8'd62, 8'd143, 8'd199, 8'd241, 8'd124, 8'd31,
      8'd231, 8'd207, 8'd249, 8'd243, 8'd252, 8'd126, 8'd63, 8'd159,
      8'd239, 8'd251, 8'd254, 8'd191:
        s = SEL_S | SEL_T | SEL_K;
      8'd247, 8'd253, 8'd127, 8'd223:
        s = SEL_K;
      default:
        s = 3'b000;
    endcase
    return s;
  endfunction

  function automatic logic st_exact(input logic [PatW-1:0] v);
    logic h;
    unique case (v)
      8'd128, 8'd32, 8'd4, 8'd1,
      8'd129, 8'd192, 8'd96, 8'd48, 8'd24, 8'd12, 8'd6, 8'd3,
      8'd208, 8'd97, 8'd67, 8'd133,
      8'd137, 8'd200, 8'd201, 8'd50, 8'd98, 8'd114, 8'd140, 8'd152,
      8'd156, 8'd35, 8'd38, 8'd39:
        h = 1'b1;
      default:
        h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic k_exact(input logic [PatW-1:0] v);
    logic h;
    unique case (v)
      8'd128, 8'd32, 8'd8, 8'd2, 8'd64, 8'd16, 8'd4, 8'd1,
      8'd65, 8'd80, 8'd5, 8'd20:
        h = 1'b1;
      default:
        h = 1'b0;
    endcase
    return h;
  endfunction

  function automatic logic uncond_hit(input logic [PatW-1:0] b,
                                      input logic [ModeW-1:0] m);
    logic vee;
    logic diag;
    logic h;
    vee  = (b[5] & b[7] & (b[1] | b[2] | b[3])) |
           (b[3] & b[5] & (b[0] | b[1] | b[7])) |
           (b[1] & b[3] & (b[5] | b[6] | b[7])) |
           (b[1] & b[7] & (b[3] | b[4] | b[5]));
    diag = (b[0] & b[3] & b[6] & ~b[7] & ~b[4] & ~b[2]) |
           (b[1] & b[4] & b[6] & ~b[5] & ~b[0] & ~b[2]) |
           (b[2] & b[4] & b[7] & ~b[3] & ~b[6] & ~b[0]) |
           (b[0] & b[2] & b[5] & ~b[1] & ~b[4] & ~b[6]);
    if (m == MODE_SKEL) begin
      h = k_exact(b) | (b[4] & b[5] & b[6]) | (b[0] & b[1] & b[2]) |
          (b[0] & b[4] & b[6]) | (b[2] & b[4] & b[6]) |
          (b[0] & b[2] & b[4]) | (b[0] & b[2] & b[6]) | vee | diag;
    end else begin
      h = st_exact(b) | (b[4] & b[5] & b[6]) |
          (b[0] & b[4] & b[6] & ((~b[1] & ~b[2] & ~b[7]) | (~b[2] & ~b[3] & ~b[5]))) |
          (b[0] & b[2] & b[4] & ((~b[3] & ~b[5] & ~b[6]) | (~b[1] & ~b[6] & ~b[7]))) |
          (b[2] & b[4] & b[6] & ((~b[0] & ~b[1] & ~b[3]) | (~b[0] & ~b[5] & ~b[7]))) |
          (b[0] & b[2] & b[6] & ((~b[4] & ~b[5] & ~b[7]) | (~b[1] & ~b[3] & ~b[4]))) |
          vee | diag;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bst_win_if.sv
// input channel carrying one 5x5 binary window per transaction
`default_nettype none
interface bst_win_if;
  logic                       valid;
  logic                       ready;
  logic [bst_pkg::WinW-1:0]   window;

  modport source (output valid, output window, input ready);
  modport sink   (input valid, input window, output ready);
endinterface
`default_nettype wire

>>> rtl/bst_res_if.sv
// output channel carrying one pass result per transaction
`default_nettype none
interface bst_res_if;
  logic valid;
  logic ready;
  logic new_pixel;
  logic marked;
  logic isolated;

  modport source (output valid, output new_pixel, output marked, output isolated,
                  input ready);
  modport sink   (input valid, input new_pixel, input marked, input isolated,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/bst_apb_regs.sv
// apb register file holding the pass mode
`default_nettype none
module bst_apb_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bst_pkg::AddrW-1:0]   paddr,
  input  wire logic [bst_pkg::DataW-1:0]   pwdata,
  output logic      [bst_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  output logic      [bst_pkg::ModeW-1:0]   mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bst_pkg::MODE_SHRINK;
    end else if (wr_en && paddr == bst_pkg::REG_MODE) begin
      mode <= pwdata[bst_pkg::ModeW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == bst_pkg::REG_MODE) begin
      prdata[bst_pkg::ModeW-1:0] = mode;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bst_core.sv
// mark logic: conditional marks of the 3x3 centre block, then unconditional test
`default_nettype none
module bst_core (
  input  wire logic [bst_pkg::WinW-1:0]  window,
  input  wire logic [bst_pkg::ModeW-1:0] mode,
  output bst_pkg::bst_res_t              res
);

  logic [2:0]               sel;
  logic [bst_pkg::PatW-1:0] centre_pat;
  logic                     centre;
  logic                     mc;
  logic [bst_pkg::PatW-1:0] mv;

  assign sel        = bst_pkg::mode_sel(mode);
  assign centre     = window[12];
  assign centre_pat = bst_pkg::pattern_at(window, 2, 2);
  assign mc         = centre & (|(bst_pkg::cond_modes(centre_pat) & sel));

  // each neighbour of the centre gets its own conditional mark
  for (genvar k = 0; k < 8; k++) begin : g_nbr
    localparam int R = 2 + bst_pkg::DR[k];
    localparam int C = 2 + bst_pkg::DC[k];
    logic [bst_pkg::PatW-1:0] p;
    assign p     = bst_pkg::pattern_at(window, R, C);
    assign mv[k] = window[5 * R + C] & (|(bst_pkg::cond_modes(p) & sel));
  end

  always_comb begin
    res.marked    = mc;
    res.new_pixel = centre & (~mc | bst_pkg::uncond_hit(mv, mode));
    res.isolated  = centre & (centre_pat == '0);
  end

endmodule
`default_nettype wire

>>> rtl/binary_shrink_thin_skeleton_pass_top.sv
// Binary shrink / thin / skeletonize pass, one pixel per transaction.
// Usage:
//   win channel: one 25-bit 5x5 binary window per transaction, bit 5*row+col,
//   centre at bit 12, off-image positions driven as 0.
//   res channel: new_pixel, marked and isolated for that window's centre.
//   apb port: register 0 (byte address 0) holds the 2-bit mode,
//   0 shrink, 1 thin, 2 skeletonize; mode 3 marks nothing. Write it only
//   while no transaction is in flight.
// Timing:
//   two register stages (input register, result register); the mask logic
//   between them sets the clock. One transaction per cycle sustained while
//   res.ready stays high.
// Reset (rst, synchronous): pipeline emptied, mode back to shrink.
// Stall: when res.ready is low the result register holds; the input
//   register still fills if empty, then win.ready drops until space opens.
`default_nettype none
module binary_shrink_thin_skeleton_pass_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bst_pkg::AddrW-1:0]   paddr,
  input  wire logic [bst_pkg::DataW-1:0]   pwdata,
  output logic      [bst_pkg::DataW-1:0]   prdata,
  output logic                             pready,
  bst_win_if.sink                          win,
  bst_res_if.source                        res
);

  logic [bst_pkg::ModeW-1:0] mode;
  logic                      s1_valid;
  logic [bst_pkg::WinW-1:0]  s1_window;
  logic                      s2_valid;
  bst_pkg::bst_res_t         s2_res;
  bst_pkg::bst_res_t         core_res;
  logic                      s1_adv;
  logic                      s2_adv;

  bst_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  bst_core u_core (
    .window (s1_window),
    .mode   (mode),
    .res    (core_res)
  );

  assign s2_adv    = ~s2_valid | res.ready;
  assign s1_adv    = ~s1_valid | s2_adv;
  assign win.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid <= win.valid;
      end
      if (s2_adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && win.valid) begin
      s1_window <= win.window;
    end
    if (s2_adv && s1_valid) begin
      s2_res <= core_res;
    end
  end

  assign res.valid     = s2_valid;
  assign res.new_pixel = s2_res.new_pixel;
  assign res.marked    = s2_res.marked;
  assign res.isolated  = s2_res.isolated;

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench for the shrink / thin / skeleton pass block
`default_nettype none
module tb_top;

  localparam int LIMIT      = 400000;
  localparam int HOLD_LEN   = 80;
  localparam int SEG_ITEMS  = 150;
  localparam int NUM_SEGS   = 8;
  localparam int TAIL_WAIT  = 4;

  localparam logic [1:0] SEG_MODE [NUM_SEGS] = '{
    bst_pkg::MODE_SHRINK, bst_pkg::MODE_THIN, bst_pkg::MODE_SKEL, bst_pkg::MODE_UNUSED,
    bst_pkg::MODE_SKEL, bst_pkg::MODE_THIN, bst_pkg::MODE_SHRINK, bst_pkg::MODE_SKEL
  };

  // neighbour order E, SE, S, SW, W, NW, N, NE
  localparam int ROW_OFS [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
  localparam int COL_OFS [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

  // conditional mask groups, by the modes that use them
  localparam logic [7:0] SHRINK_ONLY [16] = '{
    128, 32, 8, 2, 1, 64, 16, 4, 129, 192, 96, 48, 24, 12, 6, 3
  };
  localparam logic [7:0] THIN_SKEL [4] = '{65, 80, 20, 5};
  localparam logic [7:0] SHRINK_THIN [10] = '{
    97, 67, 208, 133, 193, 112, 28, 7, 99, 216
  };
  localparam logic [7:0] ALL_THREE [32] = '{
    131, 224, 56, 14, 225, 195, 240, 120, 60, 30, 15, 135,
    227, 248, 62, 143, 199, 241, 124, 31, 231, 207, 249, 243,
    252, 126, 63, 159, 239, 251, 254, 191
  };
  localparam logic [7:0] SKEL_ONLY [4] = '{247, 253, 127, 223};
  // unconditional exact patterns
  localparam logic [7:0] ST_EXACT_SET [28] = '{
    128, 32, 4, 1, 129, 192, 96, 48, 24, 12, 6, 3, 208, 97, 67, 133,
    137, 200, 201, 50, 98, 114, 140, 152, 156, 35, 38, 39
  };
  localparam logic [7:0] K_EXACT_SET [12] = '{
    128, 32, 8, 2, 64, 16, 4, 1, 65, 80, 5, 20
  };

  localparam logic [bst_pkg::WinW-1:0] FIXED_WIN [5] = '{
    25'h0000000, 25'h1FFFFFF, 25'h0001000, 25'h0007C00, 25'h1041041
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [bst_pkg::AddrW-1:0] paddr;
  logic [bst_pkg::DataW-1:0] pwdata;
  logic [bst_pkg::DataW-1:0] prdata;
  logic pready;

  bst_win_if win ();
  bst_res_if res ();

  binary_shrink_thin_skeleton_pass_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .win     (win),
    .res     (res)
  );

  logic [2:0] cond_lut [256];
  logic       st_lut [256];
  logic       k_lut [256];

  logic [1:0]                 mode_now;
  logic [bst_pkg::WinW-1:0]   window_backlog [$];
  bst_pkg::bst_res_t          pixel_expect_q [$];
  logic                       win_took;
  int                         tx_idle_pct;
  int                         rx_idle_pct;
  int                         hold_token;
  int                         hold_seen;
  int                         hold_left;
  int                         fail_count;
  int                         cycle_count;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      cond_lut[i] = '0;
      st_lut[i]   = 1'b0;
      k_lut[i]    = 1'b0;
    end
    foreach (SHRINK_ONLY[i]) cond_lut[SHRINK_ONLY[i]][bst_pkg::MODE_SHRINK] = 1'b1;
    foreach (SHRINK_THIN[i]) begin
      cond_lut[SHRINK_THIN[i]][bst_pkg::MODE_SHRINK] = 1'b1;
      cond_lut[SHRINK_THIN[i]][bst_pkg::MODE_THIN]   = 1'b1;
    end
    foreach (THIN_SKEL[i]) begin
      cond_lut[THIN_SKEL[i]][bst_pkg::MODE_THIN] = 1'b1;
      cond_lut[THIN_SKEL[i]][bst_pkg::MODE_SKEL] = 1'b1;
    end
    foreach (ALL_THREE[i]) cond_lut[ALL_THREE[i]] = 3'b111;
    foreach (SKEL_ONLY[i]) cond_lut[SKEL_ONLY[i]][bst_pkg::MODE_SKEL] = 1'b1;
    foreach (ST_EXACT_SET[i]) st_lut[ST_EXACT_SET[i]] = 1'b1;
    foreach (K_EXACT_SET[i]) k_lut[K_EXACT_SET[i]] = 1'b1;
  end

  function automatic logic px_at(input logic [bst_pkg::WinW-1:0] w, input int r, input int c);
    if (r < 0 || r > 4 || c < 0 || c > 4) return 1'b0;
    return w[5 * r + c];
  endfunction

  function automatic logic [7:0] ring_of(input logic [bst_pkg::WinW-1:0] w,
                                         input int r, input int c);
    logic [7:0] v;
    for (int k = 0; k < 8; k++) v[k] = px_at(w, r + ROW_OFS[k], c + COL_OFS[k]);
    return v;
  endfunction

  function automatic logic cond_hit(input logic [7:0] p, input logic [1:0] m);
    if (m == bst_pkg::MODE_UNUSED) return 1'b0;
    return cond_lut[p][m];
  endfunction

  function automatic logic [7:0] mark_ring(input logic [bst_pkg::WinW-1:0] w,
                                           input logic [1:0] m);
    logic [7:0] v;
    int r;
    int c;
    for (int k = 0; k < 8; k++) begin
      r = 2 + ROW_OFS[k];
      c = 2 + COL_OFS[k];
      v[k] = px_at(w, r, c) && cond_hit(ring_of(w, r, c), m);
    end
    return v;
  endfunction

  // diagonal branch: three marked spokes, with one neighbour in each gap between them clear
  function automatic logic is_branch(input logic [7:0] v);
    logic e, se, s, sw, w, nw, n, ne;
    {ne, n, nw, w, sw, s, se, e} = v;
    return (e & sw & n & ~ne & ~w & ~s) | (se & w & n & ~nw & ~e & ~s) |
           (s & w & ne & ~sw & ~n & ~e) | (e & s & nw & ~se & ~w & ~n);
  endfunction

  function automatic logic keep_hit(input logic [7:0] v, input logic [1:0] m);
    logic e, se, s, sw, w, nw, n, ne;
    logic vee;
    {ne, n, nw, w, sw, s, se, e} = v;
    vee = (nw & ne & (se | s | sw)) | (sw & nw & (e | se | ne)) |
          (se & sw & (nw | n | ne)) | (se & ne & (sw | w | nw));
    if (m == bst_pkg::MODE_SKEL)
      return k_lut[v] | (w & nw & n) | (e & se & s) | (e & w & n) | (s & w & n) |
             (e & s & w) | (e & s & n) | vee | is_branch(v);
    return st_lut[v] | (w & nw & n) |
           (e & w & n & ((~se & ~s & ~ne) | (~s & ~sw & ~nw))) |
           (e & s & w & ((~sw & ~nw & ~n) | (~se & ~n & ~ne))) |
           (s & w & n & ((~e & ~se & ~sw) | (~e & ~nw & ~ne))) |
           (e & s & n & ((~w & ~nw & ~ne) | (~se & ~sw & ~w))) |
           vee | is_branch(v);
  endfunction

  function automatic bst_pkg::bst_res_t predict_pass(input logic [bst_pkg::WinW-1:0] w,
                                                     input logic [1:0] m);
    bst_pkg::bst_res_t r;
    logic centre;
    logic mc;
    centre = w[12];
    mc = centre && cond_hit(ring_of(w, 2, 2), m);
    r.new_pixel = centre && (!mc || keep_hit(mark_ring(w, m), m));
    r.marked    = mc;
    r.isolated  = centre && (ring_of(w, 2, 2) == 8'd0);
    return r;
  endfunction

  // random window; tab set: centre ring is a conditional mask of m (shrink's if m is 3)
  function automatic logic [bst_pkg::WinW-1:0] gen_window(input logic [1:0] m, input bit tab);
    logic [bst_pkg::WinW-1:0] w;
    logic [7:0] p;
    logic [1:0] tm;
    int dens;
    case ($urandom_range(0, 4))
      0: dens = 5;
      1: dens = 25;
      2: dens = 50;
      3: dens = 75;
      default: dens = 95;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      w = bst_pkg::WinW'($urandom);
    end else begin
      for (int i = 0; i < bst_pkg::WinW; i++) w[i] = ($urandom_range(0, 99) < dens);
    end
    if (tab || $urandom_range(0, 1) == 1) begin
      tm = (m == bst_pkg::MODE_UNUSED) ? bst_pkg::MODE_SHRINK : m;
      do p = 8'($urandom_range(0, 255)); while (!cond_hit(p, tm));
      w[12] = 1'b1;
      for (int k = 0; k < 8; k++) w[5 * (2 + ROW_OFS[k]) + 2 + COL_OFS[k]] = p[k];
    end
    return w;
  endfunction

  // look for a window whose marked centre sees a diagonal branch of marks
  function automatic logic [bst_pkg::WinW-1:0] branch_window(input logic [1:0] m);
    logic [bst_pkg::WinW-1:0] w;
    w = gen_window(m, 1'b1);
    if (m == bst_pkg::MODE_UNUSED) return w;
    for (int t = 0; t < 20000; t++) begin
      if (cond_hit(ring_of(w, 2, 2), m) && is_branch(mark_ring(w, m))) return w;
      w = gen_window(m, 1'b1);
    end
    return w;
  endfunction

  task automatic write_mode(input logic [1:0] m);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bst_pkg::REG_MODE;
    pwdata  <= bst_pkg::DataW'(m);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_now = m;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (window_backlog.size() != 0 || win.valid || pixel_expect_q.size() != 0);
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      win.valid <= 1'b0;
    end else if (!win.valid || win_took) begin
      if (window_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        win.valid  <= 1'b1;
        win.window <= window_backlog.pop_front();
      end else begin
        win.valid <= 1'b0;
      end
    end
  end

  // receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // predict at the input transaction
  always @(posedge clk) begin
    win_took <= !rst && win.valid && win.ready;
    if (!rst && win.valid && win.ready)
      pixel_expect_q.push_back(predict_pass(win.window, mode_now));
  end

  // check at the output transaction
  always @(posedge clk) begin
    bst_pkg::bst_res_t want;
    if (!rst && res.valid && res.ready) begin
      if (pixel_expect_q.size() == 0) begin
        $error("result transaction with nothing outstanding");
        fail_count++;
      end else begin
        want = pixel_expect_q.pop_front();
        if (res.new_pixel !== want.new_pixel) begin
          $error("new_pixel: expected %0b, got %0b", want.new_pixel, res.new_pixel);
          fail_count++;
        end
        if (res.marked !== want.marked) begin
          $error("marked: expected %0b, got %0b", want.marked, res.marked);
          fail_count++;
        end
        if (res.isolated !== want.isolated) begin
          $error("isolated: expected %0b, got %0b", want.isolated, res.isolated);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    win.valid   = 1'b0;
    win.window  = '0;
    res.ready   = 1'b0;
    win_took    = 1'b0;
    mode_now    = bst_pkg::MODE_SHRINK;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_token  = 0;
    hold_seen   = 0;
    hold_left   = 0;
    fail_count  = 0;
    cycle_count = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, all modes: extremes, lone dot, lines; a diagonal branch save in mode 3
    for (int d = 0; d < 4; d++) begin
      write_mode(SEG_MODE[d]);
      foreach (FIXED_WIN[i]) window_backlog.push_back(FIXED_WIN[i]);
      window_backlog.push_back(branch_window(SEG_MODE[d]));
      wait_drained();
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      write_mode(SEG_MODE[seg]);
      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 66; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 66; end
        default: begin tx_idle_pct = 15; rx_idle_pct = 15; end
      endcase
      // long receiver hold while the sender keeps pushing
      if (seg % 4 == 0) hold_token++;
      for (int i = 0; i < SEG_ITEMS; i++) begin
        if (seg % 4 == 1 && i == SEG_ITEMS / 2) wait_drained();
        window_backlog.push_back(gen_window(SEG_MODE[seg], 1'b0));
      end
      wait_drained();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/bst_pkg.sv
rtl/bst_win_if.sv
rtl/bst_res_if.sv
rtl/bst_apb_regs.sv
rtl/bst_core.sv
rtl/binary_shrink_thin_skeleton_pass_top.sv
tb/tb_top.sv
